/* sv/nirt_pkg.sv */
// Shared types, codes and helpers of the NEC infrared frame transmitter.
package nirt_pkg;

	// Request codes carried by one input word.
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_FULL   = 2'd1;
	localparam logic [1:0] REQ_REPEAT = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_ADDR_CODE    = 3'd0;
	localparam logic [2:0] REG_CARRIER_ON   = 3'd1;
	localparam logic [2:0] REG_CARRIER_OFF  = 3'd2;
	localparam logic [2:0] REG_HDR_MARK     = 3'd3;
	localparam logic [2:0] REG_HDR_SPACE    = 3'd4;
	localparam logic [2:0] REG_REPEAT_SPACE = 3'd5;
	localparam logic [2:0] REG_BIT_MARK     = 3'd6;
	localparam logic [2:0] REG_ONE_SPACE    = 3'd7;

	// Segment phase codes.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_HDR_MARK  = 3'd1;
	localparam logic [2:0] PH_HDR_SPACE = 3'd2;
	localparam logic [2:0] PH_MARK      = 3'd3;
	localparam logic [2:0] PH_BIT_SPACE = 3'd4;

	// Number of data bits in a full frame.
	localparam logic [5:0] FRAME_BITS = 6'd32;

	// Register file contents as seen by the engine.
	typedef struct packed {
		logic [15:0] addr_code;
		logic [9:0]  carrier_on_ticks;
		logic [9:0]  carrier_off_ticks;
		logic [9:0]  header_mark_periods;
		logic [9:0]  header_space_periods;
		logic [9:0]  repeat_space_periods;
		logic [9:0]  bit_mark_periods;
		logic [9:0]  one_space_periods;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} res_t;

	// A count of zero is treated as one.
	function automatic logic [9:0] at_least_one(input logic [9:0] v);
		return (v == 10'd0) ? 10'd1 : v;
	endfunction

endpackage

/* sv/nirt_cfg_regs.sv */
// Configuration register file of the NEC infrared frame transmitter.
module nirt_cfg_regs import nirt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Register writes; every index selects one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_code            <= 16'd0;
			cfg_q.carrier_on_ticks     <= 10'd99;
			cfg_q.carrier_off_ticks    <= 10'd191;
			cfg_q.header_mark_periods  <= 10'd342;
			cfg_q.header_space_periods <= 10'd171;
			cfg_q.repeat_space_periods <= 10'd86;
			cfg_q.bit_mark_periods     <= 10'd21;
			cfg_q.one_space_periods    <= 10'd63;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDR_CODE:    cfg_q.addr_code            <= cfg_wdata;
				REG_CARRIER_ON:   cfg_q.carrier_on_ticks     <= cfg_wdata[9:0];
				REG_CARRIER_OFF:  cfg_q.carrier_off_ticks    <= cfg_wdata[9:0];
				REG_HDR_MARK:     cfg_q.header_mark_periods  <= cfg_wdata[9:0];
				REG_HDR_SPACE:    cfg_q.header_space_periods <= cfg_wdata[9:0];
				REG_REPEAT_SPACE: cfg_q.repeat_space_periods <= cfg_wdata[9:0];
				REG_BIT_MARK:     cfg_q.bit_mark_periods     <= cfg_wdata[9:0];
				REG_ONE_SPACE:    cfg_q.one_space_periods    <= cfg_wdata[9:0];
				default:          cfg_q.addr_code            <= cfg_q.addr_code;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/nirt_engine.sv */
// Frame sequencer and carrier generator: one tick or request per word.
module nirt_engine import nirt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	output res_t       res
);

	logic [2:0]  phase_q, phase_d;
	logic        repeat_q, repeat_d;
	logic [31:0] shift_q, shift_d;
	logic [5:0]  bitpos_q, bitpos_d;
	logic [9:0]  periods_q, periods_d;
	logic [9:0]  tick_q, tick_d;
	logic        on_q, on_d;

	logic        busy_in;
	logic        is_start;
	logic [9:0]  tick_inc;
	logic [9:0]  limit;
	logic [9:0]  periods_dec;
	logic        done;
	logic        rej;

	// Next state for the word that is being processed.
	always_comb begin
		phase_d   = (phase_q >= PH_HDR_MARK && phase_q <= PH_BIT_SPACE) ? phase_q : PH_IDLE;
		repeat_d  = repeat_q;
		shift_d   = shift_q;
		bitpos_d  = bitpos_q;
		periods_d = periods_q;
		tick_d    = tick_q;
		on_d      = on_q;
		done      = 1'b0;
		rej       = 1'b0;
		busy_in   = (phase_d != PH_IDLE);
		is_start  = (req_type == REQ_FULL) || (req_type == REQ_REPEAT);
		tick_inc  = tick_q + 10'd1;
		limit     = at_least_one(on_q ? cfg.carrier_on_ticks : cfg.carrier_off_ticks);
		periods_dec = periods_q - 10'd1;

		if (is_start && !busy_in) begin
			// Load the frame and open the header mark in its lit half.
			repeat_d  = (req_type == REQ_REPEAT);
			bitpos_d  = 6'd0;
			shift_d   = {~data_byte, data_byte, cfg.addr_code};
			phase_d   = PH_HDR_MARK;
			periods_d = at_least_one(cfg.header_mark_periods);
			tick_d    = 10'd0;
			on_d      = 1'b1;
		end else begin
			rej = is_start;
			if (busy_in) begin
				if (tick_inc < limit) begin
					tick_d = tick_inc;
				end else begin
					tick_d = 10'd0;
					if (on_q) begin
						on_d = 1'b0;
					end else begin
						on_d      = 1'b1;
						periods_d = periods_dec;
						if (periods_dec == 10'd0) begin
							// The segment is over; pick the one that follows.
							case (phase_d)
								PH_HDR_MARK: begin
									phase_d   = PH_HDR_SPACE;
									periods_d = at_least_one(repeat_q ?
										cfg.repeat_space_periods :
										cfg.header_space_periods);
								end
								PH_HDR_SPACE: begin
									phase_d   = PH_MARK;
									periods_d = at_least_one(cfg.bit_mark_periods);
								end
								PH_MARK: begin
									if (repeat_q || bitpos_q >= FRAME_BITS) begin
										phase_d   = PH_IDLE;
										tick_d    = 10'd0;
										on_d      = 1'b0;
										periods_d = 10'd0;
										done      = 1'b1;
									end else begin
										phase_d   = PH_BIT_SPACE;
										periods_d = at_least_one(shift_q[0] ?
											cfg.one_space_periods :
											cfg.bit_mark_periods);
									end
								end
								default: begin
									bitpos_d  = bitpos_q + 6'd1;
									shift_d   = {1'b0, shift_q[31:1]};
									phase_d   = PH_MARK;
									periods_d = at_least_one(cfg.bit_mark_periods);
								end
							endcase
						end
					end
				end
			end
		end

		res.busy_res   = (phase_d != PH_IDLE);
		res.ir_level   = res.busy_res && on_d &&
			(phase_d == PH_HDR_MARK || phase_d == PH_MARK);
		res.frame_done = done;
		res.rejected   = rej;
	end

	// Sequencer state advances once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			repeat_q  <= 1'b0;
			shift_q   <= 32'd0;
			bitpos_q  <= 6'd0;
			periods_q <= 10'd0;
			tick_q    <= 10'd0;
			on_q      <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			repeat_q  <= repeat_d;
			shift_q   <= shift_d;
			bitpos_q  <= bitpos_d;
			periods_q <= periods_d;
			tick_q    <= tick_d;
			on_q      <= on_d;
		end
	end

endmodule

/* sv/nec_ir_frame_transmitter_top.sv */
// Top level of the NEC infrared frame transmitter.
//
// Each input word is one time-base tick (req_type 0 or 3) or a request to
// start a full frame (1, with data_byte as command) or a repeat frame (2).
// Every input word yields exactly one result word: the LED level after
// that tick, the busy flag, a frame-done pulse and a rejected flag for a
// start request that arrived while a frame was on the air.
// Both channels use valid and stall. A word is accepted at a clock edge
// where valid is high and stall is low.
// The word is captured in an input register, the sequencer processes it
// and the result lands in the output register. One word is accepted every
// cycle while the output side takes results; the sequencer state update
// is a single pass. When the receiver stalls, the result holds in the
// output register, the input register keeps its word and in_stall rises
// once it is occupied. Configuration is written through cfg_we, cfg_index
// and cfg_wdata while the block is idle, a rule on the user that the block
// does not enforce. Reset clears the frame state and loads the default NEC
// timing (38 kHz-style carrier counts and standard segment lengths).
module nec_ir_frame_transmitter_top import nirt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ir_level,
	output logic        busy_res,
	output logic        frame_done,
	output logic        rejected
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [1:0] req_s1;
	logic [7:0] data_s1;
	logic       advance;
	logic       in_take;
	logic       out_valid_q;
	res_t       res_q;

	nirt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The input word moves on when the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1  <= req_type;
			data_s1 <= data_byte;
		end
	end

	nirt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.req_type  (req_s1),
		.data_byte (data_s1),
		.res       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign ir_level   = res_q.ir_level;
	assign busy_res   = res_q.busy_res;
	assign frame_done = res_q.frame_done;
	assign rejected   = res_q.rejected;

	// A finished frame leaves the LED dark and the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_done |-> !res_q.busy_res && !res_q.ir_level)
		else $error("frame done while still busy or lit");

	// The LED is lit only during a frame.
	a_lit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ir_level |-> res_q.busy_res)
		else $error("LED lit outside a frame");

	// Input is stalled only while the input register holds a word.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A word waiting in the input register is kept until it is processed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1) && $stable(data_s1))
		else $error("waiting input word lost or changed");

endmodule
